[sv/psl_pkg.sv]
`timescale 1ns / 1ps

package psl_pkg;

  // Frame layout
  localparam int N_FIELDS     = 4;
  localparam int CH_W         = 2;
  localparam int MAX_CHANNELS = 4;
  localparam int N_MAX        = (MAX_CHANNELS < N_FIELDS) ? MAX_CHANNELS : N_FIELDS;
  localparam int SAMPLE_W     = 24;
  localparam int ACT_W        = 3;

  // Gain and ceiling limits, Q1.23
  localparam logic [23:0] UNITY_GAIN = 24'd8388608;
  localparam logic [23:0] CEIL_MIN   = 24'd4204240;
  localparam logic [23:0] CEIL_MAX   = 24'd8388608;
  localparam logic [23:0] POS_MAX    = 24'd8388607;

  // Register reset values
  localparam logic        RST_ENABLE  = 1'b1;
  localparam logic [23:0] RST_CEILING = 24'd8388608;
  localparam logic [23:0] RST_RELEASE = 24'd16770227;
  localparam logic [2:0]  RST_ACTIVE  = 3'd2;

  // Register indexes
  localparam int          REG_IDX_W       = 2;
  localparam logic [1:0]  REG_ENABLE      = 2'd0;
  localparam logic [1:0]  REG_CEILING     = 2'd1;
  localparam logic [1:0]  REG_RELEASE     = 2'd2;
  localparam logic [1:0]  REG_ACTIVE      = 2'd3;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = 24;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            peak;
    logic            div_step;
    logic            gap;
    logic            mul_rel;
    logic            gain_upd;
    logic            scale_mul;
    logic            scale_wr;
    logic [CH_W-1:0] mul_ch;
    logic            out_load;
  } dp_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic enable;
    logic need_div;
  } dp_stat_t;

endpackage

[sv/psl_datapath.sv]
`timescale 1ns / 1ps

module psl_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic signed [23:0]   sample_ch0,
  input  logic signed [23:0]   sample_ch1,
  input  logic signed [23:0]   sample_ch2,
  input  logic signed [23:0]   sample_ch3,
  input  psl_pkg::dp_cmd_t     cmd,
  output psl_pkg::dp_stat_t    stat,
  output logic signed [23:0]   out_ch0,
  output logic signed [23:0]   out_ch1,
  output logic signed [23:0]   out_ch2,
  output logic signed [23:0]   out_ch3,
  output logic [23:0]          gain_now
);

  // Configuration and kept gain
  logic        enable;
  logic [23:0] ceiling_level;
  logic [23:0] release_coeff;
  logic [2:0]  active_channels;
  logic [23:0] smoothed_gain;

  // Frame and working registers
  logic [23:0] samp [psl_pkg::N_FIELDS];
  logic [23:0] res  [psl_pkg::N_FIELDS];
  logic [23:0] peak;
  logic        div_used;
  logic [23:0] rem;
  logic        dbit;
  logic [23:0] quo;
  logic [23:0] target;
  logic        drop;
  logic [23:0] gap;
  logic [23:0] gain;
  logic [47:0] prod;
  logic        neg_r;
  logic        act_r;
  logic [psl_pkg::CH_W-1:0] wr_idx;

  // Combinational helpers
  logic [23:0] mag [psl_pkg::N_FIELDS];
  logic [psl_pkg::N_FIELDS-1:0] act;
  logic [2:0]  n_eff;
  logic [23:0] peak_c;
  logic [23:0] ceil_v;
  logic [23:0] pos_lim;
  logic [24:0] trial;
  logic        trial_ge;
  logic [23:0] tgt_c;
  logic [23:0] gmin;
  logic [23:0] gain_new;
  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] rnd;
  logic [24:0] rmag;
  logic [23:0] lim;
  logic [23:0] rclip;
  logic [23:0] wval;

  // Effective channel count and ceiling
  always_comb begin
    if (active_channels == 3'd0) begin
      n_eff = 3'd1;
    end else if (active_channels > 3'(psl_pkg::N_MAX)) begin
      n_eff = 3'(psl_pkg::N_MAX);
    end else begin
      n_eff = active_channels;
    end
    if (ceiling_level < psl_pkg::CEIL_MIN) begin
      ceil_v = psl_pkg::CEIL_MIN;
    end else if (ceiling_level > psl_pkg::CEIL_MAX) begin
      ceil_v = psl_pkg::CEIL_MAX;
    end else begin
      ceil_v = ceiling_level;
    end
    pos_lim = ceil_v[23] ? psl_pkg::POS_MAX : ceil_v;
  end

  // Magnitudes and peak over the active channels
  always_comb begin
    peak_c = '0;
    for (int i = 0; i < psl_pkg::N_FIELDS; i++) begin
      mag[i] = samp[i][23] ? (~samp[i] + 24'd1) : samp[i];
      act[i] = (3'(i) < n_eff);
      if (act[i] && (mag[i] > peak_c)) begin
        peak_c = mag[i];
      end
    end
  end

  assign stat.enable   = enable;
  assign stat.need_div = (peak_c > ceil_v);

  // Restoring divider step
  assign trial    = {rem, dbit};
  assign trial_ge = (trial >= {1'b0, peak});

  // Target and release
  assign tgt_c    = div_used ? quo : psl_pkg::UNITY_GAIN;
  assign gmin     = (smoothed_gain > psl_pkg::UNITY_GAIN) ? psl_pkg::UNITY_GAIN
                                                           : smoothed_gain;
  assign gain_new = drop ? target : (target - prod[47:24]);

  // Shared multiplier operands
  always_comb begin
    if (cmd.mul_rel) begin
      mul_a = release_coeff;
      mul_b = gap;
    end else begin
      mul_a = mag[cmd.mul_ch];
      mul_b = gain;
    end
  end

  // Round, clamp and restore sign
  always_comb begin
    rnd   = prod + 48'd4194304;
    rmag  = rnd[47:23];
    lim   = neg_r ? ceil_v : pos_lim;
    rclip = (rmag > {1'b0, lim}) ? lim : rmag[23:0];
    wval  = neg_r ? (~rclip + 24'd1) : rclip;
  end

  // Configuration registers and kept gain
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= psl_pkg::RST_ENABLE;
      ceiling_level   <= psl_pkg::RST_CEILING;
      release_coeff   <= psl_pkg::RST_RELEASE;
      active_channels <= psl_pkg::RST_ACTIVE;
      smoothed_gain   <= psl_pkg::UNITY_GAIN;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psl_pkg::REG_ENABLE: begin
            if (cfg_data[0] != enable) begin
              smoothed_gain <= psl_pkg::UNITY_GAIN;
            end
            enable <= cfg_data[0];
          end
          psl_pkg::REG_CEILING: ceiling_level   <= cfg_data;
          psl_pkg::REG_RELEASE: release_coeff   <= cfg_data;
          psl_pkg::REG_ACTIVE:  active_channels <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.gain_upd) begin
        smoothed_gain <= gain_new;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp[0] <= sample_ch0;
      samp[1] <= sample_ch1;
      samp[2] <= sample_ch2;
      samp[3] <= sample_ch3;
    end
    if (cmd.peak) begin
      peak     <= peak_c;
      div_used <= (peak_c > ceil_v);
      rem      <= {1'b0, ceil_v[23:1]};
      dbit     <= ceil_v[0];
      quo      <= '0;
    end
    if (cmd.div_step) begin
      rem  <= trial_ge ? 24'(trial - {1'b0, peak}) : trial[23:0];
      quo  <= {quo[22:0], trial_ge};
      dbit <= 1'b0;
    end
    if (cmd.gap) begin
      target <= tgt_c;
      drop   <= (tgt_c < gmin);
      gap    <= tgt_c - gmin;
    end
    if (cmd.gain_upd) begin
      gain <= gain_new;
    end
    if (cmd.mul_rel || cmd.scale_mul) begin
      prod <= 48'(mul_a) * 48'(mul_b);
    end
    if (cmd.scale_mul) begin
      neg_r  <= samp[cmd.mul_ch][23];
      act_r  <= act[cmd.mul_ch];
      wr_idx <= cmd.mul_ch;
    end
    if (cmd.scale_wr) begin
      res[wr_idx] <= act_r ? wval : 24'd0;
    end
    if (cmd.out_load) begin
      out_ch0  <= enable ? res[0] : samp[0];
      out_ch1  <= enable ? res[1] : samp[1];
      out_ch2  <= enable ? res[2] : samp[2];
      out_ch3  <= enable ? res[3] : samp[3];
      gain_now <= enable ? gain : psl_pkg::UNITY_GAIN;
    end
  end

endmodule

[sv/psl_ctrl.sv]
`timescale 1ns / 1ps

module psl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  psl_pkg::dp_stat_t stat,
  output psl_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PEAK  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_GAP   = 3'd3;
  localparam logic [2:0] S_MULG  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [psl_pkg::CNT_W-1:0] cnt;
  logic [psl_pkg::CNT_W-1:0] cnt_next;
  logic                      out_valid_next;

  // Sequencer
  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PEAK;
        end
      end
      S_PEAK: begin
        cmd.peak = 1'b1;
        cnt_next = '0;
        if (!stat.enable) begin
          state_next = S_FIN;
        end else if (stat.need_div) begin
          state_next = S_DIV;
        end else begin
          state_next = S_GAP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == psl_pkg::CNT_W'(psl_pkg::DIV_STEPS - 1)) begin
          state_next = S_GAP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_GAP: begin
        cmd.gap    = 1'b1;
        state_next = S_MULG;
      end
      S_MULG: begin
        cmd.mul_rel = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.gain_upd = 1'b1;
        cnt_next     = '0;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        // multiply channel cnt while writing back channel cnt-1
        cmd.scale_mul = (cnt < psl_pkg::CNT_W'(psl_pkg::N_FIELDS));
        cmd.scale_wr  = (cnt != '0);
        cmd.mul_ch    = cnt[psl_pkg::CH_W-1:0];
        if (cnt == psl_pkg::CNT_W'(psl_pkg::N_FIELDS)) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[sv/peak_safety_limiter_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    sample_ch0..sample_ch3
// output    out_valid / out_ready  out_ch0..out_ch3, gain_now
// config    cfg_we (no wait)       cfg_index, cfg_data
//
// One frame at a time: a frame passes through the peak search, the bit-serial
// divider when the peak is above the ceiling, the gain update and scaling; when
// disabled, it goes straight to the output. Scaling shares one 24x24 multiplier.
// rst is synchronous; it restores register defaults and unity gain.
// A new frame is taken while the previous result sits in the output register;
// the sequencer only holds at its last step if that register is still full.

module peak_safety_limiter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  sample_ch0,
  input  logic signed [23:0]  sample_ch1,
  input  logic signed [23:0]  sample_ch2,
  input  logic signed [23:0]  sample_ch3,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_ch0,
  output logic signed [23:0]  out_ch1,
  output logic signed [23:0]  out_ch2,
  output logic signed [23:0]  out_ch3,
  output logic [23:0]         gain_now
);

  psl_pkg::dp_cmd_t  cmd;
  psl_pkg::dp_stat_t stat;

  // Sequencer
  psl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Registers, divider, multiplier and output register
  psl_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_ch0 (sample_ch0),
    .sample_ch1 (sample_ch1),
    .sample_ch2 (sample_ch2),
    .sample_ch3 (sample_ch3),
    .cmd        (cmd),
    .stat       (stat),
    .out_ch0    (out_ch0),
    .out_ch1    (out_ch1),
    .out_ch2    (out_ch2),
    .out_ch3    (out_ch3),
    .gain_now   (gain_now)
  );

endmodule

[sv/psl_checker.sv]
`timescale 1ns / 1ps

module psl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_ch0,
  input logic [23:0] gain_now
);

  // one frame in flight: ready drops right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a frame is in flight");

  // reported gain never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_now <= psl_pkg::UNITY_GAIN)
    else $error("gain above unity");

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transaction");

  // a pending result is not overwritten
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_ch0) && $stable(gain_now))
    else $error("result changed while stalled");

endmodule

bind peak_safety_limiter_unit psl_checker u_chk (.*);
